// File: design/tsls_pkg.sv
// Shared constants and types for the two-ship loading search core.
// No dependencies; imported by two_ship_loading_search_core.
package tsls_pkg;

  localparam int unsigned MaxItems = 16;
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CountW   = $clog2(MaxItems + 1);
  localparam int unsigned WeightW  = 16;
  localparam int unsigned LoadW    = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned IndexW   = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstCap  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSecondCap = CfgIdxW'(1);

  // branch taken at one search level
  typedef enum logic [1:0] {
    BR_NONE = 2'd0,
    BR_INC  = 2'd1,
    BR_EXC  = 2'd2
  } branch_e;

endpackage

// File: design/two_ship_loading_search_core.sv
// Weights are taken one beat per cycle while loading. The beat marked last starts a
// depth-first search; each tree node visited waits on the registered read of the weight memory
// at its level. The second-ship check follows, then one result beat per cycle per container
// while out_ready_i is high.
// Input is held off from the last beat until the final result is in the output register.
// Reset (rst_ni low, async): capacities zero, empty job, no result pending; weights undefined.
// Depends on tsls_pkg.
module two_ship_loading_search_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tsls_pkg::LoadW-1:0]      cfg_data_i,
  // container beats
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tsls_pkg::WeightW-1:0]    weight_i,
  input  logic                            is_last_i,
  // result beats
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tsls_pkg::IndexW-1:0]     container_index_o,
  output logic                            on_first_ship_o,
  output logic                            feasible_o,
  output logic [tsls_pkg::LoadW-1:0]      first_load_o,
  output logic                            last_o
);
  import tsls_pkg::*;

  // Search walk:
  //   ENTER  node at depth_q; leaf if depth_q >= count_q, else wait for weight read
  //   TRY    include test with the weight of this level
  //   EXC    exclude test (bound: load + rest - w must beat best)
  //   POP    depth just stepped back, weight read in flight
  //   BACK   undo the branch that returned, then try exclude or pop again
  typedef enum logic [2:0] {
    S_LOAD, S_ENTER, S_TRY, S_EXC, S_POP, S_BACK, S_CHECK, S_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [LoadW-1:0]      cap1_q, cap1_d, cap2_q, cap2_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [LoadW-1:0]      total_q, total_d;
  logic [CountW-1:0]     depth_q, depth_d;
  logic [LoadW-1:0]      load_q, load_d;
  logic [LoadW-1:0]      rem_q, rem_d;
  logic [LoadW-1:0]      best_q, best_d;
  logic [MaxItems-1:0]   choice_q, choice_d;
  logic [MaxItems-1:0]   best_choice_q, best_choice_d;
  branch_e               branch_q [MaxItems];
  branch_e               branch_d [MaxItems];
  logic                  feas_q, feas_d;
  logic [AddrW-1:0]      emit_q, emit_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [IndexW-1:0]     idx_q, idx_d;
  logic                  first_q, first_d;
  logic                  ofeas_q, ofeas_d;
  logic [LoadW-1:0]      oload_q, oload_d;
  logic                  olast_q, olast_d;

  // weight memory, one write port (loading) and one registered read port (search)
  logic [WeightW-1:0]    wmem [MaxItems];
  logic [WeightW-1:0]    rdata_q;
  logic                  wr_en;
  logic [AddrW-1:0]      lvl;
  logic                  in_beat;
  logic                  store_ok;

  logic [LoadW:0]        inc_sum;
  logic [LoadW:0]        exc_sum;
  logic [LoadW-1:0]      rest_w;
  logic                  emit_last;

  assign in_beat  = in_valid_i && in_ready_o;
  assign store_ok = (count_q < CountW'(MaxItems));
  assign wr_en    = in_beat && store_ok;
  assign lvl      = depth_q[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[count_q[AddrW-1:0]] <= weight_i;
    end
    rdata_q <= wmem[lvl];
  end

  // include fits, and the exclude bound (rem always includes this level's weight)
  assign inc_sum   = {1'b0, load_q} + (LoadW+1)'(rdata_q);
  assign exc_sum   = {1'b0, load_q} + {1'b0, rem_q - LoadW'(rdata_q)};
  assign rest_w    = total_q - best_q;
  assign emit_last = ({1'b0, emit_q} + CountW'(1)) == count_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_LOAD);

  always_comb begin
    state_d       = state_q;
    cap1_d        = cap1_q;
    cap2_d        = cap2_q;
    count_d       = count_q;
    total_d       = total_q;
    depth_d       = depth_q;
    load_d        = load_q;
    rem_d         = rem_q;
    best_d        = best_q;
    choice_d      = choice_q;
    best_choice_d = best_choice_q;
    branch_d      = branch_q;
    feas_d        = feas_q;
    emit_d        = emit_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    idx_d         = idx_q;
    first_d       = first_q;
    ofeas_d       = ofeas_q;
    oload_d       = oload_q;
    olast_d       = olast_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFirstCap:  cap1_d = cfg_data_i;
        CfgSecondCap: cap2_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_LOAD: begin
        if (in_beat) begin
          if (store_ok) begin
            count_d = count_q + CountW'(1);
            total_d = total_q + LoadW'(weight_i);
          end
          if (is_last_i) begin
            // fresh search per job
            best_d        = '0;
            best_choice_d = '0;
            choice_d      = '0;
            load_d        = '0;
            rem_d         = total_d;
            depth_d       = '0;
            state_d       = S_ENTER;
          end
        end
      end
      S_ENTER: begin
        if (depth_q >= count_q) begin
          // leaf: only a strictly heavier load replaces the best
          if (load_q > best_q) begin
            best_d        = load_q;
            best_choice_d = choice_q;
          end
          if (depth_q == '0) begin
            state_d = S_CHECK;
          end else begin
            depth_d = depth_q - CountW'(1);
            state_d = S_POP;
          end
        end else begin
          state_d = S_TRY;
        end
      end
      S_TRY: begin
        if (inc_sum <= {1'b0, cap1_q}) begin
          branch_d[lvl] = BR_INC;
          choice_d[lvl] = 1'b1;
          load_d        = inc_sum[LoadW-1:0];
          rem_d         = rem_q - LoadW'(rdata_q);
          depth_d       = depth_q + CountW'(1);
          state_d       = S_ENTER;
        end else begin
          state_d = S_EXC;
        end
      end
      S_EXC: begin
        if (exc_sum > {1'b0, best_q}) begin
          branch_d[lvl] = BR_EXC;
          choice_d[lvl] = 1'b0;
          rem_d         = rem_q - LoadW'(rdata_q);
          depth_d       = depth_q + CountW'(1);
          state_d       = S_ENTER;
        end else begin
          branch_d[lvl] = BR_NONE;
          if (depth_q == '0) begin
            state_d = S_CHECK;
          end else begin
            depth_d = depth_q - CountW'(1);
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        state_d = S_BACK;
      end
      S_BACK: begin
        if (branch_q[lvl] == BR_INC) begin
          // back from include: restore, then weigh the exclude side
          load_d  = load_q - LoadW'(rdata_q);
          rem_d   = rem_q + LoadW'(rdata_q);
          state_d = S_EXC;
        end else begin
          rem_d         = rem_q + LoadW'(rdata_q);
          branch_d[lvl] = BR_NONE;
          if (depth_q == '0) begin
            state_d = S_CHECK;
          end else begin
            depth_d = depth_q - CountW'(1);
            state_d = S_POP;
          end
        end
      end
      S_CHECK: begin
        // containers left off the first ship weigh total minus best load
        feas_d  = (rest_w <= cap2_q);
        emit_d  = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          idx_d       = IndexW'(emit_q);
          first_d     = best_choice_q[emit_q];
          ofeas_d     = feas_q;
          oload_d     = best_q;
          olast_d     = emit_last;
          emit_d      = emit_q + AddrW'(1);
          if (emit_last) begin
            count_d  = '0;
            total_d  = '0;
            choice_d = '0;
            load_d   = '0;
            rem_d    = '0;
            depth_d  = '0;
            state_d  = S_LOAD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      cap1_q        <= '0;
      cap2_q        <= '0;
      count_q       <= '0;
      total_q       <= '0;
      depth_q       <= '0;
      load_q        <= '0;
      rem_q         <= '0;
      best_q        <= '0;
      choice_q      <= '0;
      best_choice_q <= '0;
      for (int i = 0; i < MaxItems; i++) begin
        branch_q[i] <= BR_NONE;
      end
      feas_q        <= 1'b0;
      emit_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cap1_q        <= cap1_d;
      cap2_q        <= cap2_d;
      count_q       <= count_d;
      total_q       <= total_d;
      depth_q       <= depth_d;
      load_q        <= load_d;
      rem_q         <= rem_d;
      best_q        <= best_d;
      choice_q      <= choice_d;
      best_choice_q <= best_choice_d;
      branch_q      <= branch_d;
      feas_q        <= feas_d;
      emit_q        <= emit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    first_q <= first_d;
    ofeas_q <= ofeas_d;
    oload_q <= oload_d;
    olast_q <= olast_d;
  end

  assign out_valid_o       = out_valid_q;
  assign container_index_o = idx_q;
  assign on_first_ship_o   = first_q;
  assign feasible_o        = ofeas_q;
  assign first_load_o      = oload_q;
  assign last_o            = olast_q;

endmodule
